FILE: hw/rtl/ipv4_forward_decision_macros.svh
// assertion helpers for the forwarding decision block
`ifndef IPV4_FORWARD_DECISION_MACROS_SVH
`define IPV4_FORWARD_DECISION_MACROS_SVH

`define IFD_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ifd check failed");

`define IFD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ifd check failed");

`endif

FILE: hw/rtl/ifd_pkg.sv
`default_nettype none
package ifd_pkg;
  localparam int RouteSlotsDefault = 16;
  localparam int IfaceCountDefault = 4;

  localparam logic [1:0] OP_ROUTE  = 2'd0;
  localparam logic [1:0] OP_IFACE  = 2'd1;
  localparam logic [1:0] OP_PACKET = 2'd2;

  typedef enum logic [3:0] {
    ACT_DONE          = 4'd0,
    ACT_BAD_VERSION   = 4'd1,
    ACT_BAD_IHL       = 4'd2,
    ACT_LOCAL_ICMP    = 4'd3,
    ACT_PORT_UNREACH  = 4'd4,
    ACT_UNKNOWN_PROTO = 4'd5,
    ACT_TTL_EXCEEDED  = 4'd6,
    ACT_NET_UNREACH   = 4'd7,
    ACT_FORWARD       = 4'd8
  } action_t;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] MIN_IHL    = 4'd5;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // front to back: a packet that still needs the route search, or a final answer
  typedef struct packed {
    logic        search;
    action_t     action;
    logic [7:0]  ttl;
    logic [31:0] dst;
  } job_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] next_hop;
    logic [1:0]  out_port;
    logic [7:0]  new_ttl;
    logic [3:0]  route_hit;
  } result_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ifd_front.sv
`default_nettype none
module ifd_front #(
  parameter int IFACE_COUNT = ifd_pkg::IfaceCountDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   opcode,
  input  wire logic [3:0]   slot,
  input  wire logic [31:0]  iface_addr,
  input  wire logic [3:0]   pkt_version,
  input  wire logic [3:0]   pkt_ihl,
  input  wire logic [7:0]   pkt_ttl,
  input  wire logic [31:0]  pkt_dst,
  input  wire logic [7:0]   pkt_proto,
  output logic              job_valid,
  input  wire logic         job_ready,
  output ifd_pkg::job_t     job
);
  localparam int IW = (IFACE_COUNT > 1) ? $clog2(IFACE_COUNT) : 1;
  logic [31:0] iface_tab [IFACE_COUNT];
  logic [IFACE_COUNT-1:0] iface_vld;
  logic local_hit;
  ifd_pkg::job_t job_next;

  assign in_ready = !job_valid || job_ready;

  always_comb begin
    local_hit = 1'b0;
    for (int i = 0; i < IFACE_COUNT; i++) begin
      if (iface_vld[i] && iface_tab[i] == pkt_dst) local_hit = 1'b1;
    end
  end

  always_comb begin
    job_next.search = 1'b0;
    job_next.action = ifd_pkg::ACT_DONE;
    job_next.ttl = 8'd0;
    job_next.dst = pkt_dst;
    if (opcode == ifd_pkg::OP_PACKET) begin
      job_next.ttl = pkt_ttl;
      priority if (pkt_version != ifd_pkg::IP_VERSION) job_next.action = ifd_pkg::ACT_BAD_VERSION;
      else if (pkt_ihl < ifd_pkg::MIN_IHL) job_next.action = ifd_pkg::ACT_BAD_IHL;
      else if (local_hit) begin
        priority if (pkt_proto == ifd_pkg::PROTO_ICMP) job_next.action = ifd_pkg::ACT_LOCAL_ICMP;
        else if (pkt_proto == ifd_pkg::PROTO_TCP || pkt_proto == ifd_pkg::PROTO_UDP)
          job_next.action = ifd_pkg::ACT_PORT_UNREACH;
        else job_next.action = ifd_pkg::ACT_UNKNOWN_PROTO;
      end else if (pkt_ttl <= 8'd1) job_next.action = ifd_pkg::ACT_TTL_EXCEEDED;
      else job_next.search = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      iface_vld <= '0;
    end else begin
      if (in_valid && in_ready) begin
        job_valid <= 1'b1;
        if (opcode == ifd_pkg::OP_IFACE && 32'(slot) < IFACE_COUNT) begin
          iface_vld[slot[IW-1:0]] <= 1'b1;
        end
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job <= job_next;
      if (opcode == ifd_pkg::OP_IFACE && 32'(slot) < IFACE_COUNT) begin
        iface_tab[slot[IW-1:0]] <= iface_addr;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ifd_back.sv
`default_nettype none
module ifd_back #(
  parameter int ROUTE_SLOTS = ifd_pkg::RouteSlotsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [3:0]   wr_slot,
  input  wire logic [31:0]  wr_prefix,
  input  wire logic [31:0]  wr_mask,
  input  wire logic [31:0]  wr_gateway,
  input  wire logic [1:0]   wr_port,
  input  wire logic         job_valid,
  output logic              job_ready,
  input  wire ifd_pkg::job_t job,
  output logic              res_valid,
  input  wire logic         res_ready,
  output ifd_pkg::result_t  res
);
  localparam int SW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  logic [31:0] pfx [ROUTE_SLOTS];
  logic [31:0] msk [ROUTE_SLOTS];
  logic [31:0] gw  [ROUTE_SLOTS];
  logic [1:0]  prt [ROUTE_SLOTS];
  logic [ROUTE_SLOTS-1:0] vld;
  logic found, dflt;
  logic [SW-1:0] idx, didx;
  ifd_pkg::result_t res_next;

  assign job_ready = !res_valid || res_ready;

  always_comb begin
    found = 1'b0;
    dflt = 1'b0;
    idx = '0;
    didx = '0;
    for (int i = ROUTE_SLOTS - 1; i >= 0; i--) begin
      if (vld[i]) begin
        if (pfx[i] == 32'd0 && msk[i] == 32'd0) begin
          if (!dflt) didx = SW'(i);
          dflt = 1'b1;
        end else if ((job.dst & msk[i]) == (pfx[i] & msk[i])) begin
          found = 1'b1;
          idx = SW'(i);
        end
      end
    end
    if (!found) idx = didx;
  end

  always_comb begin
    res_next.action = job.action;
    res_next.next_hop = '0;
    res_next.out_port = '0;
    res_next.new_ttl = job.ttl;
    res_next.route_hit = '0;
    if (job.search) begin
      if (found || dflt) begin
        res_next.action = ifd_pkg::ACT_FORWARD;
        res_next.next_hop = gw[idx];
        res_next.out_port = prt[idx];
        res_next.new_ttl = job.ttl - 8'd1;
        res_next.route_hit = 4'(idx);
      end else begin
        res_next.action = ifd_pkg::ACT_NET_UNREACH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      vld <= '0;
    end else begin
      if (wr_en && 32'(wr_slot) < ROUTE_SLOTS) vld[SW'(wr_slot)] <= 1'b1;
      if (job_valid && job_ready) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) res <= res_next;
    if (wr_en && 32'(wr_slot) < ROUTE_SLOTS) begin
      pfx[SW'(wr_slot)] <= wr_prefix;
      msk[SW'(wr_slot)] <= wr_mask;
      gw[SW'(wr_slot)]  <= wr_gateway;
      prt[SW'(wr_slot)] <= wr_port;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ipv4_forward_decision.sv
// ipv4 forwarding decision
// s_axis: one beat per item, an opcode selects route write, interface write or
// header classify. m_axis: one result beat per accepted item, in order.
// front stage keeps the interface table, checks version, ihl, local address
// and ttl, and registers a job; back stage keeps the route table, searches all
// slots in parallel with the lowest matching slot winning, default route as fallback, and
// registers the result. route writes land in the table on acceptance, so
// following headers see them.
// an item passes through the job register and then the result register. throughput:
// one item per cycle while m_axis_tready stays high.
// reset empties both tables and both stages; no clearing pass is needed.
// when the receiver stalls, the result register and the job register hold
// and fill, then s_axis_tready drops; nothing is lost.
`default_nettype none
`include "ipv4_forward_decision_macros.svh"
module ipv4_forward_decision #(
  parameter int ROUTE_SLOTS = ifd_pkg::RouteSlotsDefault,
  parameter int IFACE_COUNT = ifd_pkg::IfaceCountDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // opcode, slot, route_prefix, route_netmask, route_gateway, route_port,
  // iface_addr, pkt_version, pkt_ihl, pkt_ttl, pkt_dst, pkt_proto
  input  wire logic [191:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // action, next_hop, out_port, new_ttl, route_hit, zero pad
  output logic [55:0]        m_axis_tdata
);
  logic [1:0]  opcode;
  logic [3:0]  slot;
  logic        job_valid, job_ready;
  ifd_pkg::job_t    job;
  ifd_pkg::result_t res;

  assign opcode = s_axis_tdata[1:0];
  assign slot   = s_axis_tdata[5:2];

  ifd_front #(.IFACE_COUNT(IFACE_COUNT)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .opcode, .slot,
    .iface_addr(s_axis_tdata[135:104]),
    .pkt_version(s_axis_tdata[139:136]),
    .pkt_ihl(s_axis_tdata[143:140]),
    .pkt_ttl(s_axis_tdata[151:144]),
    .pkt_dst(s_axis_tdata[183:152]),
    .pkt_proto(s_axis_tdata[191:184]),
    .job_valid, .job_ready, .job
  );

  ifd_back #(.ROUTE_SLOTS(ROUTE_SLOTS)) u_back (
    .clk, .rst,
    .wr_en(s_axis_tvalid && s_axis_tready && opcode == ifd_pkg::OP_ROUTE),
    .wr_slot(slot),
    .wr_prefix(s_axis_tdata[37:6]),
    .wr_mask(s_axis_tdata[69:38]),
    .wr_gateway(s_axis_tdata[101:70]),
    .wr_port(s_axis_tdata[103:102]),
    .job_valid, .job_ready, .job,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {6'd0, res.route_hit, res.new_ttl, res.out_port,
                         res.next_hop, res.action};

  `IFD_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `IFD_ASSERT_IMPL(a_fwd_ttl, clk, rst,
                   m_axis_tvalid && res.action == ifd_pkg::ACT_FORWARD, res.new_ttl != 8'hff)
  `IFD_ASSERT_IMPL(a_stall, clk, rst, job_valid && m_axis_tvalid && !m_axis_tready,
                   !s_axis_tready)
endmodule
`default_nettype wire
